[rtl/core/u8sd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared widths, operation codes and the item type passed from the byte
// classifier to the codepoint builder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int ByteW      = 8;
  localparam int CodepointW = 21;
  localparam int QueueDepth = 2;

  localparam logic [CodepointW-1:0] Replacement = CodepointW'(21'h00FFFD);

  localparam logic [1:0] OP_LITERAL = 2'd0;
  localparam logic [1:0] OP_REPLACE = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;
  localparam logic [1:0] OP_CONT    = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       last;
    logic [6:0] bits;
  } op_entry_t;

endpackage
`default_nettype wire

[rtl/core/u8sd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder channels
// Valid/ready channels for raw bytes and for decoded codepoints.
// ----------------------------------------------------------------------------
interface u8sd_byte_if;
  logic                         valid;
  logic                         ready;
  logic [u8sd_pkg::ByteW-1:0]   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8sd_cp_if;
  logic                            valid;
  logic                            ready;
  logic [u8sd_pkg::CodepointW-1:0] codepoint;
  logic                            replaced;

  modport source (output valid, output codepoint, output replaced, input ready);
  modport sink   (input valid, input codepoint, input replaced, output ready);
endinterface
`default_nettype wire

[rtl/core/utf8_stream_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Byte-serial UTF-8 decoder with a classifier, an operation queue and a
// codepoint builder.
// ----------------------------------------------------------------------------
// Usage:
//   bytes      : one raw byte of the stream per item (valid/ready).
//   codepoints : one decoded codepoint per finished character, with the
//                replaced flag set when 0xFFFD stands for a bad byte.
//   A byte is classified in the cycle it is accepted and queued; the builder
//   takes it from the queue head no earlier than the following cycle, so a
//   codepoint passes the queue slot and the output register before it shows.
//   Throughput is one byte per cycle while the queue has room. Bytes that
//   only open or extend a sequence give no codepoint.
//   When the receiver stalls, the output register holds its codepoint, the
//   queue (Depth entries) absorbs further operations, and bytes.ready falls
//   once it is full. Operations that give no output still drain while they
//   are at the head of the queue.
//   Reset clears the open-sequence count, the queue and the output valid
//   flag; the block accepts bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit #(
  parameter int Depth = u8sd_pkg::QueueDepth
) (
  input  wire logic   clk,
  input  wire logic   rst,
  u8sd_byte_if.sink   bytes,
  u8sd_cp_if.source   codepoints
);
  import u8sd_pkg::*;

  logic      push_valid;
  logic      push_ready;
  op_entry_t push_entry;
  logic      pop_valid;
  logic      pop_ready;
  op_entry_t pop_entry;

  u8sd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  u8sd_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  u8sd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .codepoints (codepoints)
  );

endmodule
`default_nettype wire

[rtl/core/u8sd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 byte classifier
// Tracks how many following bytes are still due and turns each byte into
// one operation for the codepoint builder.
// ----------------------------------------------------------------------------
module u8sd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  u8sd_byte_if.sink              bytes,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output u8sd_pkg::op_entry_t    push_entry
);
  import u8sd_pkg::*;

  logic [1:0] bytes_left;
  logic [1:0] bytes_left_next;
  logic       accept;
  logic [7:0] b;

  assign b            = bytes.data_byte;
  assign bytes.ready  = push_ready;
  assign push_valid   = bytes.valid;
  assign accept       = bytes.valid && push_ready;

  always_comb begin
    push_entry.op   = OP_REPLACE;
    push_entry.last = 1'b1;
    push_entry.bits = 7'd0;
    bytes_left_next = bytes_left;
    if (bytes_left != 2'd0) begin
      // Inside a sequence every byte is taken as a following byte, unchecked.
      push_entry.op   = OP_CONT;
      push_entry.last = (bytes_left == 2'd1);
      push_entry.bits = {1'b0, b[5:0]};
      bytes_left_next = bytes_left - 2'd1;
    end else begin
      unique casez (b)
        8'b0???????: begin
          push_entry.op   = OP_LITERAL;
          push_entry.bits = b[6:0];
        end
        8'b110?????: begin
          push_entry.op   = OP_START;
          push_entry.last = 1'b0;
          push_entry.bits = {2'b00, b[4:0]};
          bytes_left_next = 2'd1;
        end
        8'b1110????: begin
          push_entry.op   = OP_START;
          push_entry.last = 1'b0;
          push_entry.bits = {3'b000, b[3:0]};
          bytes_left_next = 2'd2;
        end
        8'b11110???: begin
          push_entry.op   = OP_START;
          push_entry.last = 1'b0;
          push_entry.bits = {4'b0000, b[2:0]};
          bytes_left_next = 2'd3;
        end
        default: begin
          push_entry.op = OP_REPLACE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 2'd0;
    end else if (accept) begin
      bytes_left <= bytes_left_next;
    end
  end

  a_lead_opens_sequence: assert property (@(posedge clk) disable iff (rst)
    accept && bytes_left == 2'd0 && push_entry.op == OP_START |=> bytes_left != 2'd0)
    else $error("lead byte did not open a sequence");

  a_last_closes_sequence: assert property (@(posedge clk) disable iff (rst)
    accept && push_entry.op == OP_CONT && push_entry.last |=> bytes_left == 2'd0)
    else $error("final following byte left the sequence open");

endmodule
`default_nettype wire

[rtl/core/u8sd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder operation queue
// Small FIFO of classified operations between classifier and builder.
// ----------------------------------------------------------------------------
module u8sd_queue #(
  parameter int Depth = u8sd_pkg::QueueDepth
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire u8sd_pkg::op_entry_t push_entry,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output u8sd_pkg::op_entry_t    pop_entry
);
  import u8sd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  op_entry_t       slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

[rtl/core/u8sd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 codepoint builder
// Carries out classified operations: gathers payload bits and holds each
// finished codepoint in an output register until it is taken.
// ----------------------------------------------------------------------------
module u8sd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire u8sd_pkg::op_entry_t pop_entry,
  u8sd_cp_if.source              codepoints
);
  import u8sd_pkg::*;

  logic [CodepointW-1:0] accumulator;
  logic [CodepointW-1:0] accumulator_next;
  logic                  out_valid;
  logic [CodepointW-1:0] out_cp;
  logic                  out_rep;
  logic                  out_free;
  logic                  emits;
  logic                  pop;

  assign out_free  = !out_valid || codepoints.ready;
  assign emits     = (pop_entry.op != OP_START) &&
                     !(pop_entry.op == OP_CONT && !pop_entry.last);
  // Items that produce no codepoint never wait on the output side.
  assign pop_ready = !emits || out_free;
  assign pop       = pop_valid && pop_ready;

  assign accumulator_next = {accumulator[CodepointW-7:0], pop_entry.bits[5:0]};

  assign codepoints.valid     = out_valid;
  assign codepoints.codepoint = out_cp;
  assign codepoints.replaced  = out_rep;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop && emits) begin
        out_valid <= 1'b1;
      end else if (codepoints.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        unique case (pop_entry.op)
          OP_LITERAL: begin
            out_cp  <= {{(CodepointW-7){1'b0}}, pop_entry.bits};
            out_rep <= 1'b0;
          end
          OP_REPLACE: begin
            out_cp  <= Replacement;
            out_rep <= 1'b1;
          end
          OP_START: begin
            accumulator <= {{(CodepointW-7){1'b0}}, pop_entry.bits};
          end
          OP_CONT: begin
            accumulator <= accumulator_next;
            if (pop_entry.last) begin
              out_cp  <= accumulator_next;
              out_rep <= 1'b0;
            end
          end
          default: begin
            accumulator <= accumulator;
          end
        endcase
      end
    end
  end

  a_emit_shows_result: assert property (@(posedge clk) disable iff (rst)
    pop && emits |=> out_valid)
    else $error("finished item did not reach the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pop && emits |-> !out_valid || codepoints.ready)
    else $error("pending codepoint overwritten");

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Feeds raw bytes into the decoder in random bursts, with the codepoint side
// stalling on a rotating pattern. A scoreboard predicts each decoded
// codepoint and compares it field by field with what the decoder emits.
// ----------------------------------------------------------------------------
module tb;
  import u8sd_pkg::*;

  localparam int TotalBytes = 1450;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [CodepointW-1:0] codepoint;
    logic                  replaced;
  } cp_item_t;

  class utf8_scoreboard;
    logic [1:0]            seq_left;
    logic [CodepointW-1:0] partial;
    cp_item_t              expected_cps[$];
    int unsigned           mismatches;

    function new();
      seq_left    = 2'd0;
      partial     = '0;
      mismatches  = 0;
    endfunction

    // Predicts the codepoint (if any) that an accepted byte completes.
    function void note_byte(logic [ByteW-1:0] b);
      if (seq_left != 2'd0) begin
        // Following bytes are taken on trust; only their low six bits count.
        partial  = {partial[CodepointW-7:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left == 2'd0) expected_cps.push_back('{partial, 1'b0});
      end else if (!b[7]) begin
        expected_cps.push_back('{CodepointW'(b), 1'b0});
      end else if (b[7:6] == 2'b10) begin
        expected_cps.push_back('{Replacement, 1'b1});
      end else if (b[7:5] == 3'b110) begin
        partial  = CodepointW'(b[4:0]);
        seq_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        partial  = CodepointW'(b[3:0]);
        seq_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        partial  = CodepointW'(b[2:0]);
        seq_left = 2'd3;
      end else begin
        expected_cps.push_back('{Replacement, 1'b1});
      end
    endfunction

    function void check_codepoint(logic [CodepointW-1:0] cp, logic rep);
      cp_item_t exp_cp;
      if (expected_cps.size() == 0) begin
        $error("codepoint %h (replaced %b) arrived with none expected", cp, rep);
        mismatches++;
        return;
      end
      exp_cp = expected_cps.pop_front();
      if (cp !== exp_cp.codepoint) begin
        $error("codepoint: expected %h, got %h", exp_cp.codepoint, cp);
        mismatches++;
      end
      if (rep !== exp_cp.replaced) begin
        $error("replaced: expected %b, got %b", exp_cp.replaced, rep);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_cps.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  u8sd_byte_if byte_ch ();
  u8sd_cp_if   cp_ch ();

  utf8_stream_decoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .bytes      (byte_ch),
    .codepoints (cp_ch)
  );

  utf8_scoreboard sb = new();

  int          bytes_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int unsigned ready_cycle = 0;
  logic [15:0] ready_pat = 16'hFFFF;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // The receiver follows a rotating 16-bit pattern that is redrawn now and then;
  // an all-ones pattern gives stretches with no stalls at all.
  always @(negedge clk) begin
    ready_cycle++;
    if (ready_cycle % 128 == 0) begin
      if ($urandom_range(0, 3) == 0) ready_pat = 16'hFFFF;
      else ready_pat = 16'($urandom()) | 16'h0001;
    end
    cp_ch.ready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[15:1]};
  end

  // Results are checked before the byte of the same edge is noted, as a
  // codepoint can never stem from the byte accepted alongside it.
  always @(posedge clk) begin
    if (!rst) begin
      if (cp_ch.valid && cp_ch.ready) sb.check_codepoint(cp_ch.codepoint, cp_ch.replaced);
      if (byte_ch.valid && byte_ch.ready) sb.note_byte(byte_ch.data_byte);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [ByteW-1:0] lead_for(int len);
    case (len)
      1:       return {1'b0, 7'($urandom())};
      2:       return {3'b110, 5'($urandom())};
      3:       return {4'b1110, 4'($urandom())};
      default: return {5'b11110, 3'($urandom())};
    endcase
  endfunction

  initial begin
    int kind;
    int len;
    int n_follow;

    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    cp_ch.ready       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: ASCII extremes, a stray continuation, the shortest and
    // longest forms of each length, unchecked following bytes, both
    // invalid lead extremes and a surrogate that passes unflagged.
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hC0); send_byte(8'h80);
    send_byte(8'hDF); send_byte(8'hBF);
    send_byte(8'hE0); send_byte(8'h80); send_byte(8'h80);
    send_byte(8'hEF); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'hF0); send_byte(8'h40); send_byte(8'hC0); send_byte(8'h3F);
    send_byte(8'hF7); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
    send_byte(8'hF8);
    send_byte(8'hFF);
    send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);

    // Mostly well-formed characters, some with arbitrary following bytes,
    // some cut short so that the next lead byte is swallowed, and noise.
    while (bytes_sent < TotalBytes) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (kind < 15) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(lead_for(len));
        n_follow = (kind < 25) ? $urandom_range(0, len - 1) : len - 1;
        repeat (n_follow) begin
          if (kind < 40) send_byte(8'($urandom_range(0, 255)));
          else send_byte({2'b10, 6'($urandom_range(0, 63))});
        end
      end
    end
    byte_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/u8sd_pkg.sv
rtl/core/u8sd_if.sv
rtl/core/u8sd_front.sv
rtl/core/u8sd_queue.sv
rtl/core/u8sd_back.sv
rtl/core/utf8_stream_decoder_unit.sv
dv/tb.sv
